// ----- hdl/packed_bit_field_array_macros.svh -----
// ----------------------------------------------------------------------------
// packed_bit_field_array assertion macros
// concurrent assertion helpers, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PACKED_BIT_FIELD_ARRAY_MACROS_SVH
`define PACKED_BIT_FIELD_ARRAY_MACROS_SVH

// same-cycle implication
`define PBFA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packed_bit_field_array: same-cycle check failed");

// next-cycle implication
`define PBFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packed_bit_field_array: next-cycle check failed");

`endif

// ----- hdl/pbfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pbfa_pkg
// shared types and constants of the packed bit-field array
// ----------------------------------------------------------------------------
package pbfa_pkg;

	localparam int WORD_COUNT_DEFAULT = 1024;
	localparam int DATA_W             = 64;
	localparam int ELEM_W_W           = 7;
	localparam int POS_W              = 16;
	localparam int OFFS_W             = 6;
	localparam int WORD_IDX_W         = 16;
	localparam int BIT_ADDR_W         = 23;
	localparam int IN_TDATA_W         = 80;
	localparam int OUT_TDATA_W        = 72;

	localparam logic [ELEM_W_W-1:0] ELEM_BITS_RESET = 7'd8;
	localparam logic [ELEM_W_W-1:0] ELEM_BITS_MAX   = 7'd64;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MODIFY
	} state_t;

	// decoded access, carried from the address stage to the modify stage
	typedef struct packed {
		kind_t               kind;
		logic                lo_odd;
		logic                straddle;
		logic                oor;
		logic [OFFS_W-1:0]   offs;
		logic [DATA_W-1:0]   mask;
	} access_t;

	function automatic logic [DATA_W-1:0] width_mask(input logic [ELEM_W_W-1:0] w);
		logic [DATA_W-1:0] m;
		if (w >= ELEM_BITS_MAX) begin
			m = '1;
		end else begin
			m = (DATA_W'(1) << w) - DATA_W'(1);
		end
		return m;
	endfunction

endpackage

// ----- hdl/pbfa_bank.sv -----
// ----------------------------------------------------------------------------
// pbfa_bank
// single-port word bank, registered read
// ----------------------------------------------------------------------------
module pbfa_bank #(
	parameter int DEPTH = pbfa_pkg::WORD_COUNT_DEFAULT / 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic                        wr_en,
	input  logic [AW-1:0]               addr,
	input  logic [pbfa_pkg::DATA_W-1:0] wr_data,
	output logic [pbfa_pkg::DATA_W-1:0] rd_data
);

	logic [pbfa_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

endmodule

// ----- hdl/pbfa_merge.sv -----
// ----------------------------------------------------------------------------
// pbfa_merge
// field extract and insert over a pair of adjacent words
// ----------------------------------------------------------------------------
module pbfa_merge (
	input  pbfa_pkg::access_t           ctl,
	input  logic [pbfa_pkg::DATA_W-1:0] lo_word,
	input  logic [pbfa_pkg::DATA_W-1:0] hi_word,
	input  logic [pbfa_pkg::DATA_W-1:0] wr_value,
	output logic [pbfa_pkg::DATA_W-1:0] rd_value,
	output logic [pbfa_pkg::DATA_W-1:0] new_lo,
	output logic [pbfa_pkg::DATA_W-1:0] new_hi
);

	localparam int PAIR_W = 2 * pbfa_pkg::DATA_W;

	logic [PAIR_W-1:0] pair;
	logic [PAIR_W-1:0] pair_shr;
	logic [PAIR_W-1:0] mask_shl;
	logic [PAIR_W-1:0] val_shl;
	logic [PAIR_W-1:0] pair_new;

	always_comb begin
		pair     = {hi_word, lo_word};
		pair_shr = pair >> ctl.offs;
		rd_value = pair_shr[pbfa_pkg::DATA_W-1:0] & ctl.mask;
		// insert the masked value, keep all other bits of both words
		mask_shl = PAIR_W'(ctl.mask) << ctl.offs;
		val_shl  = PAIR_W'(wr_value & ctl.mask) << ctl.offs;
		pair_new = (pair & ~mask_shl) | val_shl;
		new_lo   = pair_new[pbfa_pkg::DATA_W-1:0];
		new_hi   = pair_new[PAIR_W-1:pbfa_pkg::DATA_W];
	end

endmodule

// ----- hdl/packed_bit_field_array.sv -----
// ----------------------------------------------------------------------------
// packed_bit_field_array: each item passes the read and modify states of the
// read-modify-write sequencer over the even/odd bank pair, a read's result is
// registered, and no new item is taken until idle (longer while a result waits)
// reset: sequencer idle, output empty, element_bits 8; memory not cleared
// ----------------------------------------------------------------------------
module packed_bit_field_array #(
	parameter int WORD_COUNT = pbfa_pkg::WORD_COUNT_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: element_bits
	input  logic                             cfg_we,
	input  logic [pbfa_pkg::ELEM_W_W-1:0]    cfg_data,
	// item stream in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// position [15:0], write_value [79:16]
	input  logic [pbfa_pkg::IN_TDATA_W-1:0]  s_tdata,
	// kind [0]
	input  logic [0:0]                       s_tuser,
	// result stream out
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_value [63:0], out_of_range [64], zero fill [71:65]
	output logic [pbfa_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// word w lives in bank w%2 at address w/2; a straddle pair always spans both banks
	localparam int EVEN_DEPTH = (WORD_COUNT + 1) / 2;
	localparam int ODD_DEPTH  = WORD_COUNT / 2;
	localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
	localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
	localparam logic [pbfa_pkg::BIT_ADDR_W-1:0] LIMIT =
		pbfa_pkg::BIT_ADDR_W'(WORD_COUNT * pbfa_pkg::DATA_W);

	// configuration register and effective width (zero as 1, above 64 as 64)
	logic [pbfa_pkg::ELEM_W_W-1:0] elem_bits_q;
	logic [pbfa_pkg::ELEM_W_W-1:0] width_eff;

	// sequencer
	pbfa_pkg::state_t state_q;
	pbfa_pkg::state_t state_d;

	// accept stage
	pbfa_pkg::kind_t                 kind_s1;
	logic [pbfa_pkg::DATA_W-1:0]     wval_s1;
	logic [pbfa_pkg::BIT_ADDR_W-1:0] bstart_s1;
	logic [pbfa_pkg::ELEM_W_W-1:0]   width_s1;
	logic [pbfa_pkg::BIT_ADDR_W-1:0] bstart_d;

	// address stage decode
	pbfa_pkg::access_t               ctl_d;
	pbfa_pkg::access_t               ctl_s2;
	logic [pbfa_pkg::WORD_IDX_W-1:0] word;
	logic [pbfa_pkg::WORD_IDX_W:0]   word_inc;
	logic [pbfa_pkg::WORD_IDX_W-1:0] even_word;
	logic [pbfa_pkg::WORD_IDX_W-1:0] odd_word;
	logic [EVEN_AW-1:0]              even_addr_d;
	logic [ODD_AW-1:0]               odd_addr_d;
	logic [EVEN_AW-1:0]              even_addr_s2;
	logic [ODD_AW-1:0]               odd_addr_s2;
	logic [pbfa_pkg::BIT_ADDR_W-1:0] bend;
	logic [7:0]                      offs_end;

	// bank ports
	logic                        bank_rd;
	logic                        even_we;
	logic                        odd_we;
	logic [EVEN_AW-1:0]          even_addr;
	logic [ODD_AW-1:0]           odd_addr;
	logic [pbfa_pkg::DATA_W-1:0] even_rdata;
	logic [pbfa_pkg::DATA_W-1:0] odd_rdata;
	logic [pbfa_pkg::DATA_W-1:0] even_wdata;
	logic [pbfa_pkg::DATA_W-1:0] odd_wdata;

	// modify stage
	logic [pbfa_pkg::DATA_W-1:0] lo_word;
	logic [pbfa_pkg::DATA_W-1:0] hi_word;
	logic [pbfa_pkg::DATA_W-1:0] rd_value;
	logic [pbfa_pkg::DATA_W-1:0] new_lo;
	logic [pbfa_pkg::DATA_W-1:0] new_hi;
	logic                        do_write;
	logic                        out_load;
	logic                        s_accept;

	// output register
	logic                        m_tvalid_q;
	logic [pbfa_pkg::DATA_W-1:0] rd_value_q;
	logic                        oor_q;

	// element width register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_bits_q <= pbfa_pkg::ELEM_BITS_RESET;
		end else if (cfg_we) begin
			elem_bits_q <= cfg_data;
		end
	end

	always_comb begin
		if (elem_bits_q == '0) begin
			width_eff = pbfa_pkg::ELEM_W_W'(1);
		end else if (elem_bits_q > pbfa_pkg::ELEM_BITS_MAX) begin
			width_eff = pbfa_pkg::ELEM_BITS_MAX;
		end else begin
			width_eff = elem_bits_q;
		end
	end

	// first bit of the element: position times width
	assign bstart_d = pbfa_pkg::BIT_ADDR_W'(s_tdata[pbfa_pkg::POS_W-1:0])
		* pbfa_pkg::BIT_ADDR_W'(width_eff);
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1   <= pbfa_pkg::kind_t'(s_tuser[0]);
			wval_s1   <= s_tdata[pbfa_pkg::POS_W +: pbfa_pkg::DATA_W];
			bstart_s1 <= bstart_d;
			width_s1  <= width_eff;
		end
	end

	// address stage: word index, offset, straddle and range flags
	always_comb begin
		word     = bstart_s1[pbfa_pkg::OFFS_W +: pbfa_pkg::WORD_IDX_W];
		word_inc = {1'b0, word} + (pbfa_pkg::WORD_IDX_W + 1)'(1);
		bend     = bstart_s1 + pbfa_pkg::BIT_ADDR_W'(width_s1);
		offs_end = 8'(bstart_s1[pbfa_pkg::OFFS_W-1:0]) + 8'(width_s1);

		ctl_d.kind     = kind_s1;
		ctl_d.lo_odd   = word[0];
		ctl_d.offs     = bstart_s1[pbfa_pkg::OFFS_W-1:0];
		ctl_d.oor      = bend > LIMIT;
		ctl_d.straddle = offs_end > 8'(pbfa_pkg::DATA_W);
		ctl_d.mask     = pbfa_pkg::width_mask(width_s1);

		// the even bank holds word w when w is even, else word w+1
		even_word   = word[0] ? word_inc[pbfa_pkg::WORD_IDX_W:1] : {1'b0, word[15:1]};
		odd_word    = {1'b0, word[15:1]};
		even_addr_d = even_word[EVEN_AW-1:0];
		odd_addr_d  = odd_word[ODD_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == pbfa_pkg::ST_READ) begin
			ctl_s2       <= ctl_d;
			even_addr_s2 <= even_addr_d;
			odd_addr_s2  <= odd_addr_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbfa_pkg::ST_IDLE: begin
				if (s_accept) begin
					state_d = pbfa_pkg::ST_READ;
				end
			end
			pbfa_pkg::ST_READ: begin
				state_d = pbfa_pkg::ST_MODIFY;
			end
			pbfa_pkg::ST_MODIFY: begin
				// a read waits here while the output register is still full
				if (ctl_s2.kind == pbfa_pkg::KIND_WRITE || !m_tvalid_q || m_tready) begin
					state_d = pbfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbfa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		bank_rd  = 1'b0;
		do_write = 1'b0;
		out_load = 1'b0;
		case (state_q)
			pbfa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			pbfa_pkg::ST_READ: begin
				bank_rd = 1'b1;
			end
			pbfa_pkg::ST_MODIFY: begin
				if (ctl_s2.kind == pbfa_pkg::KIND_WRITE) begin
					// out-of-range writes are dropped
					do_write = !ctl_s2.oor;
				end else begin
					out_load = !m_tvalid_q || m_tready;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// bank addressing: decode in the read cycle, held copy in the write cycle
	assign even_addr = (state_q == pbfa_pkg::ST_MODIFY) ? even_addr_s2 : even_addr_d;
	assign odd_addr  = (state_q == pbfa_pkg::ST_MODIFY) ? odd_addr_s2 : odd_addr_d;

	// the low word sits in the bank of its parity, the high word in the other
	assign lo_word = ctl_s2.lo_odd ? odd_rdata : even_rdata;
	assign hi_word = ctl_s2.lo_odd ? even_rdata : odd_rdata;

	assign even_we    = do_write && (!ctl_s2.lo_odd || ctl_s2.straddle);
	assign odd_we     = do_write && (ctl_s2.lo_odd || ctl_s2.straddle);
	assign even_wdata = ctl_s2.lo_odd ? new_hi : new_lo;
	assign odd_wdata  = ctl_s2.lo_odd ? new_lo : new_hi;

	pbfa_bank #(
		.DEPTH (EVEN_DEPTH),
		.AW    (EVEN_AW)
	) u_even_bank (
		.clk     (clk),
		.rd_en   (bank_rd),
		.wr_en   (even_we),
		.addr    (even_addr),
		.wr_data (even_wdata),
		.rd_data (even_rdata)
	);

	pbfa_bank #(
		.DEPTH (ODD_DEPTH),
		.AW    (ODD_AW)
	) u_odd_bank (
		.clk     (clk),
		.rd_en   (bank_rd),
		.wr_en   (odd_we),
		.addr    (odd_addr),
		.wr_data (odd_wdata),
		.rd_data (odd_rdata)
	);

	pbfa_merge u_merge (
		.ctl      (ctl_s2),
		.lo_word  (lo_word),
		.hi_word  (hi_word),
		.wr_value (wval_s1),
		.rd_value (rd_value),
		.new_lo   (new_lo),
		.new_hi   (new_hi)
	);

	// output register, lets the next item in while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rd_value_q <= ctl_s2.oor ? '0 : rd_value;
			oor_q      <= ctl_s2.oor;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(pbfa_pkg::OUT_TDATA_W - pbfa_pkg::DATA_W - 1)'(0), oor_q, rd_value_q};

	// checks
	`include "packed_bit_field_array_macros.svh"

	`PBFA_ASSERT_NEXT(a_accept_to_read, s_accept, state_q == pbfa_pkg::ST_READ)
	`PBFA_ASSERT_NEXT(a_read_to_modify, state_q == pbfa_pkg::ST_READ,
		state_q == pbfa_pkg::ST_MODIFY)
	`PBFA_ASSERT_NOW(a_write_in_range, even_we || odd_we,
		ctl_s2.kind == pbfa_pkg::KIND_WRITE && !ctl_s2.oor)
	`PBFA_ASSERT_NOW(a_pair_only_on_straddle, even_we && odd_we, ctl_s2.straddle)

endmodule
